>>> hdl/eura_pkg.sv
// Shared constants and types for the encoder unwrap and rate average unit.
// No dependencies; used by every module in hdl/.
package eura_pkg;

  // field widths
  localparam int RAW_W       = 13;
  localparam int SPEED_W     = 16;
  localparam int TEMP_W      = 8;
  localparam int RATE_W      = 14;
  localparam int TURN_W      = 24;
  localparam int COUNT_W     = 37;
  localparam int ANGLE_W     = 43;
  localparam int FRAME_CNT_W = 3;

  // encoder geometry and scaling
  localparam int HALF_TURN      = 4096;
  localparam int FULL_TURN      = 8192;
  localparam int CAL_FRAMES     = 5;
  localparam int Q10_PER_COUNT  = 45;
  localparam int Q10_PER_TURN   = 360 * 1024;

  localparam int WINDOW_LEN_DEFAULT = 8;

  // unwrap result handed from the tracker to the output math
  typedef struct packed {
    logic                     cal;
    logic [RAW_W-1:0]         raw;
    logic signed [RATE_W-1:0] delta;
    logic signed [TURN_W-1:0] turns;
    logic signed [RATE_W-1:0] rate;
  } track_t;

endpackage

>>> hdl/encoder_unwrap_rate_average_unit.sv
// Multiturn unwrap of a 13-bit absolute encoder with a moving average of the
// angle step. Three register stages (input, unwrap, result) let a new frame in
// every cycle unless out_ready back-pressure stalls them, so throughput is one
// frame per clock while the receiver keeps up; the turn and running-sum update
// happens in the unwrap stage. The first five frames capture the bias and
// return a result with calibrating set and all other fields zero. The rate
// window is a shift line of WINDOW_LEN samples cleared by reset; the mean is
// the running sum divided by WINDOW_LEN, truncated toward zero.
module encoder_unwrap_rate_average_unit #(
  parameter int WINDOW_LEN = eura_pkg::WINDOW_LEN_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [eura_pkg::RAW_W-1:0]           raw_angle,
  input  logic signed [eura_pkg::SPEED_W-1:0]  speed_word,
  input  logic [eura_pkg::TEMP_W-1:0]          temperature_byte,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 calibrating,
  output logic signed [eura_pkg::COUNT_W-1:0]  continuous_count,
  output logic signed [eura_pkg::ANGLE_W-1:0]  angle_q10,
  output logic signed [eura_pkg::RATE_W-1:0]   step_rate,
  output logic signed [eura_pkg::RATE_W-1:0]   mean_rate,
  output logic signed [eura_pkg::SPEED_W-1:0]  speed_rpm,
  output logic [eura_pkg::TEMP_W-1:0]          temperature,
  output logic signed [eura_pkg::TURN_W-1:0]   turn_count
);

  localparam int SUM_W = eura_pkg::RATE_W + $clog2(WINDOW_LEN);

  // stage 1: input register
  logic                               v1;
  logic [eura_pkg::RAW_W-1:0]         raw1;
  logic signed [eura_pkg::SPEED_W-1:0] speed1;
  logic [eura_pkg::TEMP_W-1:0]        temp1;

  // stage 2: unwrap result
  logic                               v2;
  eura_pkg::track_t                   trk2;
  logic signed [SUM_W-1:0]            sum2;
  logic signed [eura_pkg::SPEED_W-1:0] speed2;
  logic [eura_pkg::TEMP_W-1:0]        temp2;

  // tracker outputs
  eura_pkg::track_t                   trk;
  logic signed [SUM_W-1:0]            sum_next;

  // scale outputs
  logic signed [eura_pkg::COUNT_W-1:0] count_c;
  logic signed [eura_pkg::ANGLE_W-1:0] angle_c;
  logic signed [eura_pkg::RATE_W-1:0]  rate_c;
  logic signed [eura_pkg::RATE_W-1:0]  mean_c;
  logic signed [eura_pkg::TURN_W-1:0]  turns_c;

  logic rdy3, rdy2, adv1;

  // stall chain: a stage moves when the next one is empty or moving
  assign rdy3     = !out_valid || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign in_ready = !v1 || rdy2;
  assign adv1     = v1 && rdy2;

  eura_track #(.WINDOW_LEN(WINDOW_LEN)) u_track (
    .clk      (clk),
    .rst      (rst),
    .en       (adv1),
    .raw      (raw1),
    .trk      (trk),
    .sum_next (sum_next)
  );

  eura_scale #(.WINDOW_LEN(WINDOW_LEN)) u_scale (
    .trk   (trk2),
    .sum   (sum2),
    .count (count_c),
    .angle (angle_c),
    .rate  (rate_c),
    .mean  (mean_c),
    .turns (turns_c)
  );

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        out_valid <= v2;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      raw1   <= raw_angle;
      speed1 <= speed_word;
      temp1  <= temperature_byte;
    end
    if (adv1) begin
      trk2   <= trk;
      sum2   <= sum_next;
      speed2 <= speed1;
      temp2  <= temp1;
    end
    if (rdy3 && v2) begin
      calibrating      <= trk2.cal;
      continuous_count <= count_c;
      angle_q10        <= angle_c;
      step_rate        <= rate_c;
      mean_rate        <= mean_c;
      speed_rpm        <= trk2.cal ? '0 : speed2;
      temperature      <= trk2.cal ? '0 : temp2;
      turn_count       <= turns_c;
    end
  end

`ifndef SYNTHESIS
  // after reset the pipeline is empty and takes a request
  a_ready_after_rst: assert property (@(posedge clk) rst |=> in_ready)
    else $error("in_ready low after reset");

  // a calibration result carries no position
  a_cal_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && calibrating) |->
      (continuous_count == '0 && angle_q10 == '0 && turn_count == '0))
    else $error("calibration result carries position");

  // unwrapped step stays within half a turn
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (step_rate >= -eura_pkg::HALF_TURN &&
                   step_rate <= eura_pkg::HALF_TURN))
    else $error("step_rate out of range");

  // the window mean stays within the step range
  a_mean_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (mean_rate >= -eura_pkg::HALF_TURN &&
                   mean_rate <= eura_pkg::HALF_TURN))
    else $error("mean_rate out of range");

  // count and turn outputs agree
  a_count_turns: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (continuous_count[eura_pkg::COUNT_W-1:eura_pkg::RAW_W] == turn_count))
    else $error("continuous_count disagrees with turn_count");
`endif

endmodule

>>> hdl/eura_track.sv
// Unwrap state: bias capture, turn tracking and the rate window running sum.
// Depends on eura_pkg.
module eura_track #(
  parameter int WINDOW_LEN = eura_pkg::WINDOW_LEN_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic [eura_pkg::RAW_W-1:0]   raw,
  output eura_pkg::track_t             trk,
  output logic signed [eura_pkg::RATE_W+$clog2(WINDOW_LEN)-1:0] sum_next
);

  localparam int SUM_W = eura_pkg::RATE_W + $clog2(WINDOW_LEN);
  localparam int RW    = eura_pkg::RATE_W;

  logic [eura_pkg::FRAME_CNT_W-1:0]    frame_cnt;
  logic [eura_pkg::RAW_W-1:0]          bias;
  logic [eura_pkg::RAW_W-1:0]          prev;
  logic signed [eura_pkg::TURN_W-1:0]  turns;
  logic signed [RW-1:0]                window [WINDOW_LEN];
  logic signed [SUM_W-1:0]             sum;

  logic signed [RW-1:0]                diff;
  logic signed [RW-1:0]                rate;
  logic signed [eura_pkg::TURN_W-1:0]  turns_next;
  logic                                cal;

  // wrap-corrected step and turn update
  always_comb begin
    cal  = (frame_cnt < eura_pkg::FRAME_CNT_W'(eura_pkg::CAL_FRAMES));
    diff = $signed({1'b0, raw}) - $signed({1'b0, prev});
    if (diff < -eura_pkg::HALF_TURN) begin
      rate       = diff + RW'(eura_pkg::FULL_TURN);
      turns_next = turns + eura_pkg::TURN_W'(1);
    end else if (diff > eura_pkg::HALF_TURN) begin
      rate       = diff - RW'(eura_pkg::FULL_TURN);
      turns_next = turns - eura_pkg::TURN_W'(1);
    end else begin
      rate       = diff;
      turns_next = turns;
    end
    // oldest sample leaves the window at the last tap
    sum_next  = sum - SUM_W'(window[WINDOW_LEN-1]) + SUM_W'(rate);
    trk.cal   = cal;
    trk.raw   = raw;
    trk.delta = $signed({1'b0, raw}) - $signed({1'b0, bias});
    trk.turns = turns_next;
    trk.rate  = rate;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_cnt <= '0;
      bias      <= '0;
      prev      <= '0;
      turns     <= '0;
      sum       <= '0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        window[i] <= '0;
      end
    end else if (en) begin
      if (frame_cnt <= eura_pkg::FRAME_CNT_W'(eura_pkg::CAL_FRAMES)) begin
        frame_cnt <= frame_cnt + eura_pkg::FRAME_CNT_W'(1);
      end
      prev <= raw;
      if (cal) begin
        bias <= raw;
      end else begin
        turns     <= turns_next;
        sum       <= sum_next;
        window[0] <= rate;
        for (int i = 1; i < WINDOW_LEN; i++) begin
          window[i] <= window[i-1];
        end
      end
    end
  end

endmodule

>>> hdl/eura_scale.sv
// Output math: continuous count, Q10 angle and the window mean.
// Depends on eura_pkg; purely combinational.
module eura_scale #(
  parameter int WINDOW_LEN = eura_pkg::WINDOW_LEN_DEFAULT
) (
  input  eura_pkg::track_t                                   trk,
  input  logic signed [eura_pkg::RATE_W+$clog2(WINDOW_LEN)-1:0] sum,
  output logic signed [eura_pkg::COUNT_W-1:0]                count,
  output logic signed [eura_pkg::ANGLE_W-1:0]                angle,
  output logic signed [eura_pkg::RATE_W-1:0]                 rate,
  output logic signed [eura_pkg::RATE_W-1:0]                 mean,
  output logic signed [eura_pkg::TURN_W-1:0]                 turns
);

  localparam int SUM_W       = eura_pkg::RATE_W + $clog2(WINDOW_LEN);
  localparam int RECIP_SHIFT = SUM_W - 1 + $clog2(WINDOW_LEN);
  // ceil(2^shift / N); exact floor for every magnitude the sum can reach
  localparam int RECIP       = (2**RECIP_SHIFT + WINDOW_LEN - 1) / WINDOW_LEN;
  localparam int PROD_W      = RECIP_SHIFT + eura_pkg::RATE_W;
  localparam int AW          = eura_pkg::ANGLE_W;

  logic [SUM_W-1:0]             mag_full;
  logic [PROD_W-1:0]            prod;
  logic [eura_pkg::RATE_W-1:0]  quo;

  // mean: divide magnitude by reciprocal multiply, then restore sign
  always_comb begin
    mag_full = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    prod     = PROD_W'(mag_full[SUM_W-2:0]) * PROD_W'(RECIP);
    quo      = prod[RECIP_SHIFT +: eura_pkg::RATE_W];
    if (trk.cal) begin
      count = '0;
      angle = '0;
      rate  = '0;
      mean  = '0;
      turns = '0;
    end else begin
      count = {trk.turns, trk.raw};
      angle = AW'(trk.delta) * AW'(eura_pkg::Q10_PER_COUNT)
            + AW'(trk.turns) * AW'(eura_pkg::Q10_PER_TURN);
      rate  = trk.rate;
      mean  = sum[SUM_W-1] ? $signed(-quo) : $signed(quo);
      turns = trk.turns;
    end
  end

endmodule

>>> dv/encoder_unwrap_rate_average_checker.sv
// Scoreboard for the encoder unwrap and rate average unit: tracks the feedback
// requests and checks every returned result against its own unwrap prediction.
// Depends on eura_pkg (hdl/eura_pkg.sv).
`timescale 1ns / 1ps

module encoder_unwrap_rate_average_checker #(
  parameter int WINDOW_LEN = eura_pkg::WINDOW_LEN_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic [eura_pkg::RAW_W-1:0]           raw_angle,
  input  logic signed [eura_pkg::SPEED_W-1:0]  speed_word,
  input  logic [eura_pkg::TEMP_W-1:0]          temperature_byte,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic                                 calibrating,
  input  logic signed [eura_pkg::COUNT_W-1:0]  continuous_count,
  input  logic signed [eura_pkg::ANGLE_W-1:0]  angle_q10,
  input  logic signed [eura_pkg::RATE_W-1:0]   step_rate,
  input  logic signed [eura_pkg::RATE_W-1:0]   mean_rate,
  input  logic signed [eura_pkg::SPEED_W-1:0]  speed_rpm,
  input  logic [eura_pkg::TEMP_W-1:0]          temperature,
  input  logic signed [eura_pkg::TURN_W-1:0]   turn_count,
  output int                                   fail_count,
  output int                                   pending_count,
  output int                                   checked_count,
  output int                                   wrap_count
);
  import eura_pkg::*;

  typedef struct {
    logic                      cal;
    logic signed [COUNT_W-1:0] count;
    logic signed [ANGLE_W-1:0] angle;
    logic signed [RATE_W-1:0]  step;
    logic signed [RATE_W-1:0]  mean;
    logic signed [SPEED_W-1:0] speed;
    logic [TEMP_W-1:0]         temp;
    logic signed [TURN_W-1:0]  turns;
  } feedback_result_t;

  feedback_result_t expected_results[$];

  // tracker state, mirrors the unit after reset
  logic [FRAME_CNT_W-1:0]   frames_seen;
  logic [RAW_W-1:0]         bias;
  logic [RAW_W-1:0]         last_angle;
  logic signed [TURN_W-1:0] turns_acc;
  int                       rate_hist[WINDOW_LEN];
  int                       hist_pos;
  int                       rate_sum;

  int errors  = 0;
  int checked = 0;
  int wraps   = 0;

  // unwrap one frame and update the tracker; returns the result it should give
  function automatic feedback_result_t unwrap_frame(
    logic [RAW_W-1:0] raw, logic signed [SPEED_W-1:0] speed, logic [TEMP_W-1:0] temp
  );
    feedback_result_t r;
    int               diff;
    int               rate;
    longint           cnt;
    longint           ang;
    r.cal   = 1'b0;
    r.count = '0;
    r.angle = '0;
    r.step  = '0;
    r.mean  = '0;
    r.speed = '0;
    r.temp  = '0;
    r.turns = '0;

    if (frames_seen < 6) frames_seen = frames_seen + 1'b1;

    // calibration: capture bias, everything else reads zero
    if (frames_seen <= CAL_FRAMES) begin
      bias       = raw;
      last_angle = raw;
      r.cal      = 1'b1;
      return r;
    end

    // half-turn rule: a larger jump means the shaft crossed zero
    diff = int'(raw) - int'(last_angle);
    if (diff < -HALF_TURN) begin
      turns_acc = turns_acc + 1'b1;
      rate      = diff + FULL_TURN;
      wraps++;
    end else if (diff > HALF_TURN) begin
      turns_acc = turns_acc - 1'b1;
      rate      = diff - FULL_TURN;
      wraps++;
    end else begin
      rate = diff;
    end
    last_angle = raw;

    // running window sum; int division truncates toward zero
    rate_sum            = rate_sum - rate_hist[hist_pos] + rate;
    rate_hist[hist_pos] = rate;
    hist_pos            = (hist_pos + 1) % WINDOW_LEN;

    cnt = longint'(raw) + longint'(turns_acc) * FULL_TURN;
    ang = (longint'(raw) - longint'(bias)) * Q10_PER_COUNT
        + longint'(turns_acc) * Q10_PER_TURN;

    r.count = cnt[COUNT_W-1:0];
    r.angle = ang[ANGLE_W-1:0];
    r.step  = rate[RATE_W-1:0];
    r.mean  = RATE_W'(rate_sum / WINDOW_LEN);
    r.speed = speed;
    r.temp  = temp;
    r.turns = turns_acc;
    return r;
  endfunction

  task automatic check_field(string label, logic signed [63:0] want,
                             logic signed [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: mismatch on %s: expected %0d, got %0d", $time, label, want, got);
    end
  endtask

  // results are compared first; a request in the same cycle lands behind them
  always @(posedge clk) begin : monitor
    feedback_result_t want;
    if (rst) begin
      frames_seen = '0;
      bias        = '0;
      last_angle  = '0;
      turns_acc   = '0;
      hist_pos    = 0;
      rate_sum    = 0;
      foreach (rate_hist[i]) rate_hist[i] = 0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: result with no request outstanding (count %0d)", $time,
                   continuous_count);
        end else begin
          want = expected_results.pop_front();
          checked++;
          check_field("calibrating", want.cal, calibrating);
          check_field("continuous_count", want.count, continuous_count);
          check_field("angle_q10", want.angle, angle_q10);
          check_field("step_rate", want.step, step_rate);
          check_field("mean_rate", want.mean, mean_rate);
          check_field("speed_rpm", want.speed, speed_rpm);
          check_field("temperature", want.temp, temperature);
          check_field("turn_count", want.turns, turn_count);
        end
      end
      if (in_valid && in_ready)
        expected_results.push_back(unwrap_frame(raw_angle, speed_word, temperature_byte));
    end
    fail_count    <= errors;
    pending_count <= expected_results.size();
    checked_count <= checked;
    wrap_count    <= wraps;
  end

endmodule

>>> dv/tb_encoder_unwrap_rate_average_unit.sv
// Top of the encoder unwrap testbench: clock, reset, feedback requests and the
// verdict. Depends on eura_pkg, the unit itself and the checker in this folder.
`timescale 1ns / 1ps

module tb_encoder_unwrap_rate_average_unit;
  import eura_pkg::*;

  localparam int RANDOM_PER_PHASE = 300;
  localparam int STALL_LIMIT      = 2000;
  localparam int TAIL_CYCLES      = 10;

  logic                      clk              = 1'b0;
  logic                      rst              = 1'b1;
  logic                      in_valid         = 1'b0;
  logic                      in_ready;
  logic [RAW_W-1:0]          raw_angle        = '0;
  logic signed [SPEED_W-1:0] speed_word       = '0;
  logic [TEMP_W-1:0]         temperature_byte = '0;
  logic                      out_valid;
  logic                      out_ready        = 1'b0;
  logic                      calibrating;
  logic signed [COUNT_W-1:0] continuous_count;
  logic signed [ANGLE_W-1:0] angle_q10;
  logic signed [RATE_W-1:0]  step_rate;
  logic signed [RATE_W-1:0]  mean_rate;
  logic signed [SPEED_W-1:0] speed_rpm;
  logic [TEMP_W-1:0]         temperature;
  logic signed [TURN_W-1:0]  turn_count;

  int fail_count;
  int pending_count;
  int checked_count;
  int wrap_count;

  int gap_pct   = 0;
  int stall_pct = 0;
  int sent      = 0;
  int idle_cycles = 0;

  // simulated shaft for the random part
  logic [RAW_W-1:0] shaft     = '0;
  int               spin      = 0;
  int               spin_left = 0;

  always #5 clk = ~clk;

  encoder_unwrap_rate_average_unit u_dut (
    .clk, .rst, .in_valid, .in_ready, .raw_angle, .speed_word, .temperature_byte,
    .out_valid, .out_ready, .calibrating, .continuous_count, .angle_q10, .step_rate,
    .mean_rate, .speed_rpm, .temperature, .turn_count
  );

  encoder_unwrap_rate_average_checker u_checker (
    .clk, .rst, .in_valid, .in_ready, .raw_angle, .speed_word, .temperature_byte,
    .out_valid, .out_ready, .calibrating, .continuous_count, .angle_q10, .step_rate,
    .mean_rate, .speed_rpm, .temperature, .turn_count,
    .fail_count, .pending_count, .checked_count, .wrap_count
  );

  // receiver backpressure
  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  // watchdog: no request and no result accepted for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // one request per call; valid stays up across back-to-back requests
  task automatic send_frame(input logic [RAW_W-1:0] raw,
                            input logic signed [SPEED_W-1:0] speed,
                            input logic [TEMP_W-1:0] temp);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    raw_angle        <= raw;
    speed_word       <= speed;
    temperature_byte <= temp;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // mostly steady spins, some steps right at the half-turn line, some jumps
  task automatic send_random_frame();
    int pick;
    int step;
    int pos;
    if (spin_left == 0) begin
      if ($urandom_range(3) == 0) spin = int'($urandom_range(8192)) - HALF_TURN;
      else spin = int'($urandom_range(128)) - 64;
      spin_left = $urandom_range(40, 5);
    end
    spin_left--;
    pick = $urandom_range(99);
    if (pick < 70) begin
      step = spin + int'($urandom_range(8)) - 4;
    end else if (pick < 85) begin
      step = HALF_TURN - 1 + int'($urandom_range(2));
      if ($urandom_range(1)) step = -step;
    end else begin
      step = int'($urandom_range(FULL_TURN - 1)) - int'(shaft);
    end
    pos   = int'(shaft) + step;
    shaft = pos[RAW_W-1:0];
    send_frame(shaft, SPEED_W'($urandom), TEMP_W'($urandom));
  endtask

  // hold requests off until every outstanding result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    gap_pct   = 25;
    stall_pct = 64;

    // calibration frames with field extremes; bias ends at 4000
    send_frame(13'd0,    -16'sd32768, 8'd0);
    send_frame(13'd8191,  16'sd32767, 8'd255);
    send_frame(13'd100,   16'sd0,     8'd1);
    send_frame(13'd8191, -16'sd1,     8'd128);
    send_frame(13'd4000,  16'sd1,     8'd254);
    // no motion, then steps on and just past the half-turn line both ways
    send_frame(13'd4000,  16'sd0,     8'd0);
    send_frame(13'd8096,  16'sd32767, 8'd255);  // +4096, no wrap
    send_frame(13'd0,    -16'sd32768, 8'd7);    // forward turn
    send_frame(13'd4096,  16'sd5,     8'd0);    // +4096
    send_frame(13'd8191, -16'sd5,     8'd255);  // +4095
    send_frame(13'd0,     16'sd100,   8'd3);    // forward turn, step 1
    send_frame(13'd4097, -16'sd100,   8'd4);    // +4097 -> reverse turn
    send_frame(13'd1,     16'sd0,     8'd5);    // -4096, no wrap
    send_frame(13'd8191,  16'sd0,     8'd6);    // reverse turn, step -2
    send_frame(13'd0,     16'sd0,     8'd7);    // forward turn
    send_frame(13'd8191,  16'sd0,     8'd8);    // reverse turn
    send_frame(13'd8191,  16'sd0,     8'd9);
    send_frame(13'd0,     16'sd0,     8'd10);
    // negative running sum so the mean truncates toward zero
    send_frame(13'd8188,  16'sd0,     8'd11);
    send_frame(13'd8187,  16'sd0,     8'd12);
    shaft = 13'd8187;
    drain_results();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin gap_pct = 25; stall_pct = 64; end
        1: begin gap_pct = 64; stall_pct = 25; end
        default: begin gap_pct = 0; stall_pct = 0; end
      endcase
      repeat (RANDOM_PER_PHASE) send_random_frame();
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Summary: %0d feedback frames sent (calibration, half-turn edges, spins,",
             sent);
    $display("  jumps) under three stall patterns; %0d results checked, %0d turn crossings",
             checked_count, wrap_count);
    if (fail_count == 0 && pending_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> filelist.f
hdl/eura_pkg.sv
hdl/eura_track.sv
hdl/eura_scale.sv
hdl/encoder_unwrap_rate_average_unit.sv
dv/encoder_unwrap_rate_average_checker.sv
dv/tb_encoder_unwrap_rate_average_unit.sv
